[rtl/qrfk_pkg.sv]
// Shared types, constants and slot arithmetic for the reversible word queue.
package qrfk_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int SUM_W    = IDX_W + 1;
   localparam int CNT_W    = 5;
   localparam int K_W      = 5;
   localparam int WORD_W   = 32;

   localparam logic [1:0] OP_ENQ = 2'd0;
   localparam logic [1:0] OP_DEQ = 2'd1;
   localparam logic [1:0] OP_REV = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_EMPTY   = 2'd2;
   localparam logic [1:0] STAT_INVALID = 2'd3;

   localparam logic [WORD_W-1:0] MINUS_ONE = '1;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [WORD_W-1:0] value;
      logic [K_W-1:0]           k;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [1:0]               status;
      logic [CNT_W-1:0]         count;
   } rsp_type;

   // physical slot of a queue offset, wrapping at CAPACITY
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

[rtl/queue_reverse_first_k.sv]
// Circular queue of signed words with in-place reversal of the first k entries.
// The request is accepted in S_IDLE and the response is registered out of S_DONE (reverse: see below).
// Enqueue, dequeue and rejected requests go from S_IDLE to S_DONE; one request in flight.
// Reverse swaps floor(k/2) pairs, one memory access per state: read a, read b, write a, write b.
// Reset (synchronous) empties the queue and drops any response; no memory clearing pass.
module queue_reverse_first_k
   import qrfk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD_A = 3'd1;
   localparam logic [2:0] S_RD_B = 3'd2;
   localparam logic [2:0] S_WR_A = 3'd3;
   localparam logic [2:0] S_WR_B = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [WORD_W-1:0] tmp_ff, tmp_in;
   logic [1:0]        status_ff, status_in;
   logic              use_rd_ff, use_rd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   logic [WORD_W-1:0] storage_ff [CAPACITY];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata;

   logic              req_fire;
   logic [K_W-1:0]    k_m1;
   logic [SUM_W-1:0]  lo_p2;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign k_m1        = req_payload.k - K_W'(1);
   assign lo_p2       = {1'b0, lo_ff} + SUM_W'(2);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      tmp_in         = tmp_ff;
      status_in      = status_ff;
      use_rd_in      = use_rd_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = '0;
      mem_raddr      = '0;
      mem_wdata      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = STAT_OK;
               use_rd_in = 1'b0;
               state_in  = S_DONE;
               case (req_payload.op)
                  OP_ENQ: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = slot_of(head_ff, count_ff[IDX_W-1:0]);
                        mem_wdata = req_payload.value;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_DEQ: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = head_ff;
                        use_rd_in = 1'b1;
                        head_in   = slot_of(head_ff, IDX_W'(1));
                        count_in  = count_ff - CNT_W'(1);
                     end
                  end
                  OP_REV: begin
                     if (req_payload.k == '0 || req_payload.k > count_ff) begin
                        status_in = STAT_INVALID;
                     end else if (req_payload.k != K_W'(1)) begin
                        lo_in    = '0;
                        hi_in    = k_m1[IDX_W-1:0];
                        state_in = S_RD_A;
                     end
                  end
                  default: begin
                     status_in = STAT_INVALID;
                  end
               endcase
            end
         end
         S_RD_A: begin
            mem_re    = 1'b1;
            mem_raddr = slot_of(head_ff, lo_ff);
            state_in  = S_RD_B;
         end
         S_RD_B: begin
            // low word arrives now; fetch the high word
            mem_re    = 1'b1;
            mem_raddr = slot_of(head_ff, hi_ff);
            tmp_in    = rd_data_ff;
            state_in  = S_WR_A;
         end
         S_WR_A: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(head_ff, lo_ff);
            mem_wdata = rd_data_ff;
            state_in  = S_WR_B;
         end
         S_WR_B: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(head_ff, hi_ff);
            mem_wdata = tmp_ff;
            lo_in     = lo_ff + IDX_W'(1);
            hi_in     = hi_ff - IDX_W'(1);
            if (lo_p2 < {1'b0, hi_ff}) begin
               state_in = S_RD_A;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_payload_in.data   = use_rd_ff ? $signed(rd_data_ff) : $signed(MINUS_ONE);
               rsp_payload_in.status = status_ff;
               rsp_payload_in.count  = count_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      tmp_ff         <= tmp_in;
      status_ff      <= status_in;
      use_rd_ff      <= use_rd_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         storage_ff[mem_waddr] <= mem_wdata;
      end
   end

   // read data holds between reads; dequeue result is taken from it later
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= storage_ff[mem_raddr];
      end
   end

endmodule

[rtl/qrfk_checker.sv]
// Port-level assertions for the reversible word queue, bound to the top level.
module qrfk_checker
   import qrfk_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // one request in flight: an accepted request blocks the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   // a request that does not succeed returns -1 as its data
   a_data_minus_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STAT_OK |-> rsp_payload.data == $signed(MINUS_ONE))
      else $error("failed request returned data");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.count <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_status_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STAT_FULL || rsp_payload.status == STAT_EMPTY)
      |-> (rsp_payload.status == STAT_FULL && rsp_payload.count == CNT_W'(CAPACITY)) ||
          (rsp_payload.status == STAT_EMPTY && rsp_payload.count == '0))
      else $error("full or empty status disagrees with count");

endmodule

bind queue_reverse_first_k qrfk_checker u_qrfk_checker (.*);
